// ===== design/vmrit_pkg.sv =====
// Shared types and constants for the region interval table.
package vmrit_pkg;

    localparam int unsigned START_W = 32;
    localparam int unsigned END_W   = 33;

    localparam logic [END_W-1:0] SPACE_END = 33'h1_0000_0000;

    localparam logic [2:0] OP_MAP     = 3'd0;
    localparam logic [2:0] OP_UNMAP   = 3'd1;
    localparam logic [2:0] OP_PROTECT = 3'd2;
    localparam logic [2:0] OP_INHERIT = 3'd3;
    localparam logic [2:0] OP_CHECK   = 3'd4;
    localparam logic [2:0] OP_FIND    = 3'd5;

    typedef struct packed {
        logic [2:0]         operation;
        logic [START_W-1:0] range_start;
        logic [END_W-1:0]   range_end;
        logic [2:0]         perm_bits;
        logic [1:0]         inherit_code;
    } t_op_in;

    typedef struct packed {
        logic               ok;
        logic               table_full;
        logic [START_W-1:0] found_start;
        logic [END_W-1:0]   found_end;
        logic [2:0]         found_perm;
        logic [1:0]         found_inherit;
    } t_op_out;

    typedef struct packed {
        logic [START_W-1:0] s;
        logic [END_W-1:0]   e;
        logic [2:0]         p;
        logic [1:0]         h;
    } t_region;

    localparam int unsigned REGION_W = $bits(t_region);

endpackage

// ===== design/vmrit_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vmrit_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/vm_region_interval_table.sv =====
// Region interval table: the sorted region list sits in two RAM banks. Each
// valid operation streams the current bank at most once, entry by entry, and
// changing operations write the rebuilt, coalesced list into the other bank,
// which becomes current only on success. A pass takes, for each stored region,
// a read, a load and four piece steps, then an end check, tail, flush and the
// result, which waits while a stalled result holds the output register. A
// region query does a read and a load on each region it reads and stops at
// the first match. A bad range or unknown code goes straight to the result.
// The next item is taken as soon as the result has been placed in the output
// register.
module vm_region_interval_table
    import vmrit_pkg::*;
#(
    parameter int unsigned MAX_REGIONS = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_op_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_op_out o_out_data
);

    localparam int unsigned AW = $clog2(MAX_REGIONS);
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_LD, ST_PC, ST_TAIL, ST_FLUSH, ST_DONE
    } t_state;

    t_state  r_state, n_state;
    t_op_in  r_op, n_op;
    logic    r_rng_ok, n_rng_ok;
    logic [CW-1:0] r_idx, n_idx, r_wcnt, n_wcnt, r_count, n_count;
    logic [1:0] r_k, n_k;
    t_region r_cur, n_cur, r_pend, n_pend, r_fnd, n_fnd;
    logic    r_pend_v, n_pend_v;
    logic [END_W-1:0] r_c, n_c;
    logic    r_over, n_over, r_gap, n_gap, r_pfail, n_pfail, r_found, n_found;
    logic    r_bank, n_bank;
    logic    r_out_v, n_out_v;
    t_op_out r_out, n_out;

    // RAM ports
    logic    we0, we1, wr_en;
    logic [AW-1:0] waddr;
    t_region wdata;
    logic [REGION_W-1:0] rd0, rd1;
    t_region rdata;

    // piece logic
    t_region em;
    logic    em_v, em_gap;
    logic [END_W-1:0] s33, st33, lo, hi;
    logic    rng_ok_in, changing;

    vmrit_ram #(.WIDTH(REGION_W), .DEPTH(MAX_REGIONS)) u_bank0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(rd0)
    );

    vmrit_ram #(.WIDTH(REGION_W), .DEPTH(MAX_REGIONS)) u_bank1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(rd1)
    );

    assign rdata = r_bank ? t_region'(rd1) : t_region'(rd0);
    assign we0 = wr_en && r_bank;
    assign we1 = wr_en && !r_bank;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign rng_ok_in = (i_in_data.range_end > {1'b0, i_in_data.range_start}) &&
                       (i_in_data.range_end <= SPACE_END);
    assign s33  = {1'b0, r_cur.s};
    assign st33 = {1'b0, r_op.range_start};
    assign lo   = (s33 > st33) ? s33 : st33;
    assign hi   = (r_cur.e < r_op.range_end) ? r_cur.e : r_op.range_end;

    // Candidate piece for this step: gap before the region, part below the
    // range, part inside, part above; the tail step emits the trailing gap.
    always_comb begin
        em     = r_cur;
        em_v   = 1'b0;
        em_gap = 1'b0;
        if (r_state == ST_TAIL) begin
            em_gap = (r_c < r_op.range_end);
            em     = '{s: r_c[START_W-1:0], e: r_op.range_end,
                       p: r_op.perm_bits, h: r_op.inherit_code};
            em_v   = em_gap && (r_op.operation == OP_MAP);
        end else if (r_state == ST_PC) begin
            case (r_k)
                2'd0: begin
                    em_gap = (r_c < r_op.range_end) && (s33 > r_c);
                    em     = '{s: r_c[START_W-1:0],
                               e: (s33 < r_op.range_end) ? s33 : r_op.range_end,
                               p: r_op.perm_bits, h: r_op.inherit_code};
                    em_v   = em_gap && (r_op.operation == OP_MAP);
                end
                2'd1: begin
                    em.e = (r_cur.e < st33) ? r_cur.e : st33;
                    em_v = (s33 < st33) && (r_op.operation <= OP_INHERIT);
                end
                2'd2: begin
                    em.s = lo[START_W-1:0];
                    em.e = hi;
                    case (r_op.operation)
                        OP_MAP:     em.p = r_cur.p | r_op.perm_bits;
                        OP_PROTECT: em.p = r_op.perm_bits;
                        OP_INHERIT: em.h = r_op.inherit_code;
                        default:    em   = em;
                    endcase
                    em_v = (lo < hi) && (r_op.operation <= OP_INHERIT) &&
                           (r_op.operation != OP_UNMAP);
                end
                default: begin
                    em.s = (s33 > r_op.range_end) ? r_cur.s
                                                  : r_op.range_end[START_W-1:0];
                    em_v = (r_cur.e > r_op.range_end) && (r_op.operation <= OP_INHERIT);
                end
            endcase
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_rng_ok = r_rng_ok;
        n_idx    = r_idx;
        n_wcnt   = r_wcnt;
        n_count  = r_count;
        n_k      = r_k;
        n_cur    = r_cur;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_fnd    = r_fnd;
        n_c      = r_c;
        n_over   = r_over;
        n_gap    = r_gap;
        n_pfail  = r_pfail;
        n_found  = r_found;
        n_bank   = r_bank;
        n_out_v  = r_out_v;
        n_out    = r_out;
        wr_en    = 1'b0;
        waddr    = r_wcnt[AW-1:0];
        wdata    = r_pend;
        changing = 1'b0;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        // coalesce into the pending region, or retire it to the new bank
        if (em_v) begin
            if (r_pend_v && r_pend.e == {1'b0, em.s} && r_pend.p == em.p &&
                r_pend.h == em.h) begin
                n_pend.e = em.e;
            end else begin
                if (r_pend_v) begin
                    if (r_wcnt == CNT_MAX) begin
                        n_over = 1'b1;
                    end else begin
                        wr_en  = 1'b1;
                        n_wcnt = r_wcnt + 1'b1;
                    end
                end
                n_pend   = em;
                n_pend_v = 1'b1;
            end
        end
        if (em_gap) begin
            n_gap = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data;
                    n_rng_ok = rng_ok_in;
                    n_idx    = '0;
                    n_wcnt   = '0;
                    n_k      = '0;
                    n_pend_v = 1'b0;
                    n_c      = {1'b0, i_in_data.range_start};
                    n_over   = 1'b0;
                    n_gap    = 1'b0;
                    n_pfail  = 1'b0;
                    n_found  = 1'b0;
                    if ((i_in_data.operation <= OP_CHECK && rng_ok_in) ||
                        i_in_data.operation == OP_FIND) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD: begin
                if (r_idx == r_count) begin
                    n_state = (r_op.operation == OP_FIND) ? ST_DONE : ST_TAIL;
                end else begin
                    n_state = ST_LD;
                end
            end
            ST_LD: begin
                n_cur = rdata;
                n_k   = '0;
                if (r_op.operation == OP_FIND) begin
                    if (rdata.e > st33) begin
                        n_found = 1'b1;
                        n_fnd   = rdata;
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_RD;
                    end
                end else begin
                    n_state = ST_PC;
                end
            end
            ST_PC: begin
                if (r_k == 2'd2 && r_op.operation == OP_CHECK && lo < hi &&
                    (r_cur.p & r_op.perm_bits) != r_op.perm_bits) begin
                    n_pfail = 1'b1;
                end
                if (r_k == 2'd3) begin
                    if (r_cur.e > r_c) begin
                        n_c = r_cur.e;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_TAIL: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (r_pend_v) begin
                    n_pend_v = 1'b0;
                    if (r_wcnt == CNT_MAX) begin
                        n_over = 1'b1;
                    end else begin
                        wr_en  = 1'b1;
                        n_wcnt = r_wcnt + 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_v || !i_out_stall) begin
                    n_out   = '0;
                    n_out_v = 1'b1;
                    case (r_op.operation)
                        OP_MAP, OP_UNMAP:       changing = r_rng_ok;
                        OP_PROTECT, OP_INHERIT: changing = r_rng_ok && !r_gap;
                        OP_CHECK: n_out.ok = r_rng_ok && !r_gap && !r_pfail;
                        OP_FIND: begin
                            if (r_found) begin
                                n_out.ok            = 1'b1;
                                n_out.found_start   = r_fnd.s;
                                n_out.found_end     = r_fnd.e;
                                n_out.found_perm    = r_fnd.p;
                                n_out.found_inherit = r_fnd.h;
                            end
                        end
                        default: n_out = '0;
                    endcase
                    if (changing) begin
                        if (r_over) begin
                            n_out.table_full = 1'b1;
                        end else begin
                            n_out.ok = 1'b1;
                            n_bank   = !r_bank;
                            n_count  = r_wcnt;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bank   <= n_bank;
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
        r_op     <= n_op;
        r_rng_ok <= n_rng_ok;
        r_idx    <= n_idx;
        r_wcnt   <= n_wcnt;
        r_k      <= n_k;
        r_cur    <= n_cur;
        r_pend   <= n_pend;
        r_fnd    <= n_fnd;
        r_c      <= n_c;
        r_over   <= n_over;
        r_gap    <= n_gap;
        r_pfail  <= n_pfail;
        r_found  <= n_found;
        r_out    <= n_out;
    end

endmodule

// ===== design/vmrit_checker.sv =====
// Port-level checker for the region interval table, bound to the top level.
module vmrit_checker
    import vmrit_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input t_op_in  i_in_data,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_op_out o_out_data
);

    // a stalled operation holds until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled operation changed");

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_ok_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.ok && o_out_data.table_full))
        else $error("ok and table_full both set");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |->
            o_out_data.found_start == '0 && o_out_data.found_end == '0)
        else $error("found fields set on failure");

    a_found_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found_end != '0 |->
            o_out_data.found_end > {1'b0, o_out_data.found_start})
        else $error("reported region is empty");

endmodule

bind vm_region_interval_table vmrit_checker u_vmrit_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .i_in_data(i_in_data), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);
